FILE: hw/rtl/gwm_pkg.sv
`default_nettype none
package gwm_pkg;

	typedef enum logic [1:0] {
		CMD_PAT  = 2'd0,
		CMD_TXT  = 2'd1,
		CMD_EVAL = 2'd2,
		CMD_CLR  = 2'd3
	} gwm_cmd_t;

	typedef enum logic [1:0] {
		ST_NOMATCH  = 2'd0,
		ST_MATCH    = 2'd1,
		ST_UNCLOSED = 2'd2,
		ST_OVERFLOW = 2'd3
	} gwm_status_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_LOOP,
		M_DECODE,
		M_ESC,
		M_SCAN,
		M_CNEG,
		M_CFIRST,
		M_CDASH,
		M_CLAST,
		M_TAIL,
		M_TAILCHK
	} gwm_state_t;

	// finish report from the walker
	typedef struct packed {
		logic        done;
		gwm_status_t status;
	} gwm_res_t;

	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	// lower ASCII letters unless comparing exactly
	function automatic logic [7:0] fold(input logic [7:0] b, input logic cs);
		if (!cs && b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'd32;
		end
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gwm_buffers.sv
`default_nettype none
module gwm_buffers #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT    = 256,
	parameter int PA          = 6,
	parameter int TA          = 8
) (
	input  wire logic          clk,
	input  wire logic          pat_we,
	input  wire logic [PA-1:0] pat_waddr,
	input  wire logic [PA-1:0] pat_raddr,
	output logic      [7:0]    pat_rdata,
	input  wire logic          txt_we,
	input  wire logic [TA-1:0] txt_waddr,
	input  wire logic [TA-1:0] txt_raddr,
	output logic      [7:0]    txt_rdata,
	input  wire logic [7:0]    wdata
);

	logic [7:0] pat_mem [MAX_PATTERN];
	logic [7:0] txt_mem [MAX_TEXT];

	// pattern store, registered read
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_waddr] <= wdata;
		end
		pat_rdata <= pat_mem[pat_raddr];
	end

	// text store, registered read
	always_ff @(posedge clk) begin
		if (txt_we) begin
			txt_mem[txt_waddr] <= wdata;
		end
		txt_rdata <= txt_mem[txt_raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/gwm_matcher.sv
`default_nettype none
module gwm_matcher #(
	parameter int PLW = 7,
	parameter int TLW = 9,
	parameter int PA  = 6,
	parameter int TA  = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic            cs,
	input  wire logic [PLW-1:0]  plen,
	input  wire logic [TLW-1:0]  tlen,
	input  wire logic [7:0]      pat_rdata,
	input  wire logic [7:0]      txt_rdata,
	output logic      [PA-1:0]   pat_raddr,
	output logic      [TA-1:0]   txt_raddr,
	output logic                 busy,
	output gwm_pkg::gwm_res_t    res
);
	import gwm_pkg::*;

	localparam int CIW = PLW + 1;

	gwm_state_t state_q, state_d;

	logic [PLW-1:0] pi_q, pi_d, spi_q, spi_d, end_q, end_d;
	logic [TLW-1:0] ti_q, ti_d, sti_q, sti_d;
	logic [CIW-1:0] ci_q, ci_d;
	logic           star_q, star_d, neg_q, neg_d, ok_q, ok_d;
	logic [7:0]     tc_q, tc_d, first_q, first_d;

	logic [7:0]     pd, td;
	logic [CIW-1:0] pi_x, lo_x, hi_x, plen_x, end1_x, raddr_x;
	logic           t_done, p_in, hit, plain_eq, esc_eq, cls_fin, cls_hit;

	assign pd      = fold(pat_rdata, cs);
	assign td      = fold(txt_rdata, cs);
	assign pi_x    = CIW'(pi_q);
	assign lo_x    = pi_x + CIW'(1);
	assign hi_x    = CIW'(end_q);
	assign plen_x  = CIW'(plen);
	assign end1_x  = hi_x + CIW'(1);
	assign t_done  = (ti_q >= tlen);
	assign p_in    = (pi_q < plen);
	assign plain_eq = (pd == td);
	assign esc_eq  = (pd == tc_q);
	assign hit     = neg_q ^ ok_q;
	// class walk ends: empty body or index reaches the closing bracket
	assign cls_fin = ((state_q == M_CNEG) && (lo_x >= hi_x))
		|| ((state_q == M_CFIRST) && (ci_q >= hi_x));
	assign cls_hit = (state_q == M_CFIRST) && hit;
	assign busy    = (state_q != M_IDLE);

	// mismatch: back off to the last star or fail
	logic miss;
	always_comb begin
		miss = 1'b0;
		case (state_q)
			M_LOOP:   miss = !t_done && !p_in;
			M_DECODE: begin
				if (pd == CH_BSLASH) begin
					miss = (lo_x >= plen_x);
				end else if (pd != CH_QUEST && pd != CH_LBRK && pd != CH_STAR) begin
					miss = !plain_eq;
				end
			end
			M_ESC:    miss = !esc_eq;
			M_CNEG,
			M_CFIRST: miss = cls_fin && !cls_hit;
			default:  miss = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			M_IDLE: if (go) begin
				state_d = M_LOOP;
			end
			M_LOOP: begin
				if (t_done) state_d = M_TAIL;
				else if (p_in) state_d = M_DECODE;
			end
			M_DECODE: begin
				if (pd == CH_BSLASH) state_d = M_ESC;
				else if (pd == CH_LBRK) state_d = (lo_x >= plen_x) ? M_IDLE : M_SCAN;
				else state_d = M_LOOP;
			end
			M_ESC: state_d = M_LOOP;
			M_SCAN: begin
				if (pd == CH_RBRK) state_d = M_CNEG;
				else if (end1_x >= plen_x) state_d = M_IDLE;
			end
			M_CNEG: state_d = cls_fin ? M_LOOP : M_CFIRST;
			M_CFIRST: begin
				if (cls_fin) state_d = M_LOOP;
				else if (ci_q + CIW'(2) < hi_x) state_d = M_CDASH;
			end
			M_CDASH: state_d = (pd == CH_DASH) ? M_CLAST : M_CFIRST;
			M_CLAST: state_d = M_CFIRST;
			M_TAIL: state_d = p_in ? M_TAILCHK : M_IDLE;
			M_TAILCHK: state_d = (pd == CH_STAR) ? M_TAIL : M_IDLE;
			default: state_d = M_IDLE;
		endcase
		if (miss) begin
			state_d = star_q ? M_LOOP : M_IDLE;
		end
	end

	// datapath updates, read addresses and finish report
	always_comb begin
		pi_d = pi_q; ti_d = ti_q; spi_d = spi_q; sti_d = sti_q;
		end_d = end_q; ci_d = ci_q; star_d = star_q; neg_d = neg_q;
		ok_d = ok_q; tc_d = tc_q; first_d = first_q;
		raddr_x = '0;
		res.done = 1'b0;
		res.status = ST_NOMATCH;
		case (state_q)
			M_IDLE: if (go) begin
				pi_d = '0; ti_d = '0; star_d = 1'b0;
			end
			M_LOOP: raddr_x = pi_x;
			M_DECODE: begin
				tc_d = td;
				if (pd == CH_QUEST) begin
					pi_d = pi_q + PLW'(1); ti_d = ti_q + TLW'(1);
				end else if (pd == CH_BSLASH) begin
					pi_d = pi_q + PLW'(1);
					raddr_x = lo_x;
				end else if (pd == CH_LBRK) begin
					end_d = pi_q + PLW'(1);
					raddr_x = lo_x;
					if (lo_x >= plen_x) begin
						res.done = 1'b1; res.status = ST_UNCLOSED;
					end
				end else if (pd == CH_STAR) begin
					star_d = 1'b1; spi_d = pi_q; sti_d = ti_q;
					pi_d = pi_q + PLW'(1);
				end else if (plain_eq) begin
					pi_d = pi_q + PLW'(1); ti_d = ti_q + TLW'(1);
				end
			end
			M_ESC: if (esc_eq) begin
				pi_d = pi_q + PLW'(1); ti_d = ti_q + TLW'(1);
			end
			M_SCAN: begin
				if (pd == CH_RBRK) begin
					raddr_x = lo_x;
				end else begin
					end_d = end_q + PLW'(1);
					raddr_x = end1_x;
					if (end1_x >= plen_x) begin
						res.done = 1'b1; res.status = ST_UNCLOSED;
					end
				end
			end
			M_CNEG: begin
				ok_d = 1'b0;
				if (pd == CH_BANG) begin
					neg_d = 1'b1; ci_d = lo_x + CIW'(1); raddr_x = lo_x + CIW'(1);
				end else begin
					neg_d = 1'b0; ci_d = lo_x; raddr_x = lo_x;
				end
			end
			M_CFIRST: if (!cls_fin) begin
				first_d = pd;
				raddr_x = ci_q + CIW'(1);
				if (!(ci_q + CIW'(2) < hi_x)) begin
					ok_d = ok_q | (pd == tc_q);
					ci_d = ci_q + CIW'(1);
				end
			end
			M_CDASH: begin
				if (pd == CH_DASH) begin
					raddr_x = ci_q + CIW'(2);
				end else begin
					ok_d = ok_q | (first_q == tc_q);
					ci_d = ci_q + CIW'(1);
					raddr_x = ci_q + CIW'(1);
				end
			end
			M_CLAST: begin
				ok_d = ok_q | ((first_q <= tc_q) && (tc_q <= pd));
				ci_d = ci_q + CIW'(3);
				raddr_x = ci_q + CIW'(3);
			end
			M_TAIL: begin
				raddr_x = pi_x;
				if (!p_in) begin
					res.done = 1'b1; res.status = ST_MATCH;
				end
			end
			M_TAILCHK: begin
				if (pd == CH_STAR) begin
					pi_d = pi_q + PLW'(1);
				end else begin
					res.done = 1'b1; res.status = ST_NOMATCH;
				end
			end
			default: ;
		endcase
		// class accepted the byte: step past the closing bracket
		if (cls_fin && cls_hit) begin
			pi_d = end_q + PLW'(1); ti_d = ti_q + TLW'(1);
		end
		if (miss) begin
			if (star_q) begin
				sti_d = sti_q + TLW'(1);
				ti_d  = sti_q + TLW'(1);
				pi_d  = spi_q + PLW'(1);
			end else begin
				res.done = 1'b1; res.status = ST_NOMATCH;
			end
		end
	end

	assign pat_raddr = raddr_x[PA-1:0];
	assign txt_raddr = ti_q[TA-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		pi_q <= pi_d; ti_q <= ti_d; spi_q <= spi_d; sti_q <= sti_d;
		end_q <= end_d; ci_q <= ci_d; star_q <= star_d; neg_q <= neg_d;
		ok_q <= ok_d; tc_q <= tc_d; first_q <= first_d;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/glob_wildcard_matcher_unit.sv
// Channel  | Ports                          | Dir | Handshake
// ---------+--------------------------------+-----+--------------------------
// request  | start, command, data_byte      | in  | start & !busy
// result   | result_valid, match_status     | out | one-cycle strobe
// config   | cfg_wr_en, cfg_wr_data         | in  | write on cfg_wr_en
//
// Load, append and clear requests leave busy low.
// Evaluate: each plain pattern byte is read and then compared, an escape adds a read of
// the escaped byte; a class scans to its closing bracket, then walks its body bytes.
// Star backtracking repeats the walk: time grows with pattern times text length.
// Result strobes the cycle after the walk ends; overflow reports next cycle.
// Reset clears lengths, flags and sets exact comparison; the receiver cannot stall.
`default_nettype none
module glob_wildcard_matcher_unit #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT    = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] command,
	input  wire logic [7:0] data_byte,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	output logic            result_valid,
	output logic      [1:0] match_status
);
	import gwm_pkg::*;

	localparam int PLW = $clog2(MAX_PATTERN + 1);
	localparam int TLW = $clog2(MAX_TEXT + 1);
	localparam int PA  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int TA  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

	logic [PLW-1:0] plen_q;
	logic [TLW-1:0] tlen_q;
	logic           povf_q, tovf_q, cs_q;
	logic           valid_q;
	gwm_status_t    status_q;

	logic           acc, pat_we, txt_we, go, ovf_eval;
	logic [PA-1:0]  pat_raddr;
	logic [TA-1:0]  txt_raddr;
	logic [7:0]     pat_rdata, txt_rdata;
	gwm_res_t       res;
	gwm_cmd_t       cmd;

	assign cmd      = gwm_cmd_t'(command);
	assign acc      = start && !busy;
	assign pat_we   = acc && (cmd == CMD_PAT) && (plen_q < PLW'(MAX_PATTERN));
	assign txt_we   = acc && (cmd == CMD_TXT) && (tlen_q < TLW'(MAX_TEXT));
	assign ovf_eval = acc && (cmd == CMD_EVAL) && (povf_q || tovf_q);
	assign go       = acc && (cmd == CMD_EVAL) && !(povf_q || tovf_q);

	gwm_buffers #(
		.MAX_PATTERN(MAX_PATTERN), .MAX_TEXT(MAX_TEXT), .PA(PA), .TA(TA)
	) u_buf (
		.clk       (clk),
		.pat_we    (pat_we),
		.pat_waddr (plen_q[PA-1:0]),
		.pat_raddr (pat_raddr),
		.pat_rdata (pat_rdata),
		.txt_we    (txt_we),
		.txt_waddr (tlen_q[TA-1:0]),
		.txt_raddr (txt_raddr),
		.txt_rdata (txt_rdata),
		.wdata     (data_byte)
	);

	gwm_matcher #(.PLW(PLW), .TLW(TLW), .PA(PA), .TA(TA)) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cs        (cs_q),
		.plen      (plen_q),
		.tlen      (tlen_q),
		.pat_rdata (pat_rdata),
		.txt_rdata (txt_rdata),
		.pat_raddr (pat_raddr),
		.txt_raddr (txt_raddr),
		.busy      (busy),
		.res       (res)
	);

	// buffer lengths, overflow flags and the case register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0; povf_q <= 1'b0;
			tlen_q <= '0; tovf_q <= 1'b0;
			cs_q   <= 1'b1;
		end else begin
			if (cfg_wr_en) cs_q <= cfg_wr_data;
			if (acc && cmd == CMD_PAT) begin
				if (pat_we) plen_q <= plen_q + PLW'(1);
				else povf_q <= 1'b1;
			end
			if (acc && cmd == CMD_TXT) begin
				if (txt_we) tlen_q <= tlen_q + TLW'(1);
				else tovf_q <= 1'b1;
			end
			if (acc && cmd == CMD_CLR) begin
				plen_q <= '0; povf_q <= 1'b0;
			end
			if (ovf_eval || res.done) begin
				tlen_q <= '0; tovf_q <= 1'b0;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ovf_eval || res.done;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= ovf_eval ? ST_OVERFLOW : res.status;
	end

	assign result_valid = valid_q;
	assign match_status = status_q;

`ifndef SYNTHESIS
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while walking");
	a_eval_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_EVAL) |=> (busy || result_valid))
		else $error("evaluate request lost");
	a_text_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (tlen_q == '0 && !tovf_q)) else $error("text not cleared");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(plen_q <= PLW'(MAX_PATTERN)) && (tlen_q <= TLW'(MAX_TEXT)))
		else $error("length past store depth");
`endif

endmodule
`default_nettype wire
